### design/dfu_pkg.sv
// Shared types, constants and helpers for the delimited field unescaper.
`default_nettype none
package dfu_pkg;

    localparam logic [7:0] BRACE_OPEN    = 8'h7B;
    localparam logic [7:0] BRACE_CLOSE   = 8'h7D;
    localparam logic [7:0] BRACKET_OPEN  = 8'h5B;
    localparam logic [7:0] BRACKET_CLOSE = 8'h5D;
    localparam logic [7:0] BACKSLASH     = 8'h5C;

    localparam logic DELIM_BRACES   = 1'b0;
    localparam logic DELIM_BRACKETS = 1'b1;

    typedef enum logic [2:0] {
        MODE_SEARCH = 3'd0,
        MODE_FIELD  = 3'd1,
        MODE_CLOSER = 3'd2,
        MODE_ESC1   = 3'd3,
        MODE_ESC2   = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] nibble;
        logic       nibble_hex;
    } parse_state_t;

    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic       byte_valid;
        logic       field_end;
    } step_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/dfu_step.sv
// Per-word parse step: next parser state and the result word for one input byte.
`default_nettype none
module dfu_step (
    input  wire logic                  delim_kind,
    input  wire dfu_pkg::parse_state_t state_cur,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  eot,
    output dfu_pkg::parse_state_t      state_nxt,
    output dfu_pkg::step_result_t      result
);

    logic [7:0]          opener;
    logic [7:0]          closer;
    dfu_pkg::hex_digit_t digit;

    assign opener = (delim_kind == dfu_pkg::DELIM_BRACKETS) ? dfu_pkg::BRACKET_OPEN
                                                            : dfu_pkg::BRACE_OPEN;
    assign closer = (delim_kind == dfu_pkg::DELIM_BRACKETS) ? dfu_pkg::BRACKET_CLOSE
                                                            : dfu_pkg::BRACE_CLOSE;
    assign digit  = dfu_pkg::hex_decode(in_byte);

    always_comb
    begin
        state_nxt = state_cur;
        case (state_cur.mode)
            dfu_pkg::MODE_FIELD:
            begin
                if (eot) begin
                    state_nxt.mode = dfu_pkg::MODE_SEARCH;
                end else if (in_byte == closer) begin
                    state_nxt.mode = dfu_pkg::MODE_CLOSER;
                end else if (in_byte == dfu_pkg::BACKSLASH) begin
                    state_nxt.mode = dfu_pkg::MODE_ESC1;
                end else begin
                    state_nxt.mode = dfu_pkg::MODE_FIELD;
                end
            end
            dfu_pkg::MODE_CLOSER:
            begin
                if (eot) begin
                    state_nxt.mode = dfu_pkg::MODE_SEARCH;
                end else if (in_byte == closer || in_byte == opener) begin
                    state_nxt.mode = dfu_pkg::MODE_FIELD;
                end else begin
                    state_nxt.mode = dfu_pkg::MODE_SEARCH;
                end
            end
            dfu_pkg::MODE_ESC1:
            begin
                if (in_byte == dfu_pkg::BACKSLASH) begin
                    state_nxt.mode = eot ? dfu_pkg::MODE_SEARCH : dfu_pkg::MODE_FIELD;
                end else begin
                    state_nxt.nibble     = digit.value;
                    state_nxt.nibble_hex = digit.ok;
                    state_nxt.mode       = eot ? dfu_pkg::MODE_SEARCH : dfu_pkg::MODE_ESC2;
                end
            end
            dfu_pkg::MODE_ESC2:
            begin
                state_nxt.mode = eot ? dfu_pkg::MODE_SEARCH : dfu_pkg::MODE_FIELD;
            end
            default:
            begin
                if (in_byte == opener && !eot) begin
                    state_nxt.mode = dfu_pkg::MODE_FIELD;
                end else begin
                    state_nxt.mode = dfu_pkg::MODE_SEARCH;
                end
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        case (state_cur.mode)
            dfu_pkg::MODE_FIELD:
            begin
                if (in_byte == closer || in_byte == dfu_pkg::BACKSLASH) begin
                    result.has       = eot;
                    result.field_end = eot;
                end else begin
                    result.has        = 1'b1;
                    result.byte_valid = 1'b1;
                    result.data       = in_byte;
                    result.field_end  = eot;
                end
            end
            dfu_pkg::MODE_CLOSER:
            begin
                result.has = 1'b1;
                if (in_byte == closer) begin
                    result.byte_valid = 1'b1;
                    result.data       = in_byte;
                    result.field_end  = eot;
                end else begin
                    result.field_end = 1'b1;
                end
            end
            dfu_pkg::MODE_ESC1:
            begin
                if (in_byte == dfu_pkg::BACKSLASH) begin
                    result.has        = 1'b1;
                    result.byte_valid = 1'b1;
                    result.data       = in_byte;
                    result.field_end  = eot;
                end else if (eot) begin
                    result.has        = 1'b1;
                    result.byte_valid = 1'b1;
                    result.data       = {4'd0, digit.value};
                    result.field_end  = 1'b1;
                end
            end
            dfu_pkg::MODE_ESC2:
            begin
                result.has        = 1'b1;
                result.byte_valid = 1'b1;
                result.field_end  = eot;
                if (!state_cur.nibble_hex) begin
                    result.data = 8'd0;
                end else if (digit.ok) begin
                    result.data = {state_cur.nibble, digit.value};
                end else begin
                    result.data = {4'd0, state_cur.nibble};
                end
            end
            default:
            begin
                if (in_byte == opener && eot) begin
                    result.has       = 1'b1;
                    result.field_end = 1'b1;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

### design/delimited_field_unescaper.sv
// Top level of the delimited field unescaper: word registers, parser state, output stage.
//
// Usage:
//   s_*   : input stream, one raw text byte per word in s_tdata; s_tlast marks the
//           final byte of the text.
//   m_*   : decoded stream; m_tdata carries the decoded byte (zero when m_tuser is 0),
//           m_tuser = 1 when m_tdata is a decoded byte, m_tlast = 1 at field end.
//           A word may carry both a byte and the field end.
//   cfg_* : delimiter select, 0 = braces, 1 = square brackets; write only while idle.
//   Input words that decode to nothing produce no output word.
// Timing: an accepted word is held and parsed in the input register, and its result
//   is registered in the output register that drives m_*. One word per cycle is
//   accepted sustained unless m_* stalls; input and output registers hold one word each.
// Stall: while m_tready is low and a result waits, a word that yields a result holds
//   in the input register and s_tready drops; words that yield nothing still pass.
// Reset: parser returns to searching for an opener, both registers empty, braces
//   selected.
`default_nettype none
module delimited_field_unescaper (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // byte_valid
    output logic            m_tlast,   // field_end
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_data   // [0] delimiter_kind
);

    logic                  delim_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_eot_reg;
    dfu_pkg::parse_state_t state_reg;
    dfu_pkg::parse_state_t state_next;
    dfu_pkg::step_result_t step_res;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_bv_reg;
    logic                  out_end_reg;
    logic                  advance;

    dfu_step u_step (
        .delim_kind (delim_reg),
        .state_cur  (state_reg),
        .in_byte    (in_byte_reg),
        .eot        (in_eot_reg),
        .state_nxt  (state_next),
        .result     (step_res)
    );

    assign advance   = in_valid_reg && (!step_res.has || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= dfu_pkg::DELIM_BRACES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            delim_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= dfu_pkg::MODE_SEARCH;
            state_reg.nibble     <= 4'd0;
            state_reg.nibble_hex <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step_res.has)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.has)
        begin
            out_byte_reg <= step_res.data;
            out_bv_reg   <= step_res.byte_valid;
            out_end_reg  <= step_res.field_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_bv_reg;
    assign m_tlast  = out_end_reg;

`ifndef NO_ASSERTIONS
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("output word carries neither byte nor field end");

    a_zero_when_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("output byte nonzero without byte_valid");

    a_eot_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eot_reg) |=> (state_reg.mode == dfu_pkg::MODE_SEARCH))
        else $error("parser not searching after end of text");
`endif

endmodule
`default_nettype wire

### tb/dfu_field_checker.sv
// Checker for the delimited field unescaper: tracks the parser, queues decoded words, compares.
`timescale 1ns / 1ps
module dfu_field_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [0:0] cfg_data,
    output int         mismatches,
    output int         words_due,
    output int         words_checked,
    output int         fields_closed
);

    typedef struct packed {
        logic [7:0] text;
        logic       is_byte;
        logic       closes;
    } decoded_word_t;

    decoded_word_t decoded_words_due[$];

    dfu_pkg::mode_t scan_mode;
    logic [3:0]     high_digit;
    logic           high_digit_ok;
    logic           delim_kind;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'b0_0000;
    endfunction

    task automatic queue_word(input logic [7:0] text, input logic is_byte, input logic closes);
        decoded_word_t w;
        w.text    = text;
        w.is_byte = is_byte;
        w.closes  = closes;
        decoded_words_due.push_back(w);
    endtask

    task automatic decode_text_byte(input logic [7:0] c, input logic eot);
        logic [7:0]     opener;
        logic [7:0]     closer;
        logic [4:0]     digit;
        dfu_pkg::mode_t was;
        opener = delim_kind ? dfu_pkg::BRACKET_OPEN : dfu_pkg::BRACE_OPEN;
        closer = delim_kind ? dfu_pkg::BRACKET_CLOSE : dfu_pkg::BRACE_CLOSE;
        was    = scan_mode;
        if (eot)
            scan_mode = dfu_pkg::MODE_SEARCH;
        case (was)
            dfu_pkg::MODE_FIELD:
            begin
                if (c == closer || c == dfu_pkg::BACKSLASH)
                begin
                    if (eot)
                        queue_word(8'h00, 1'b0, 1'b1);
                    else
                        scan_mode = (c == closer) ? dfu_pkg::MODE_CLOSER : dfu_pkg::MODE_ESC1;
                end
                else
                    queue_word(c, 1'b1, eot);
            end
            dfu_pkg::MODE_CLOSER:
            begin
                if (c == closer)
                begin
                    if (!eot)
                        scan_mode = dfu_pkg::MODE_FIELD;
                    queue_word(c, 1'b1, eot);
                end
                else
                begin
                    if (!eot)
                        scan_mode = (c == opener) ? dfu_pkg::MODE_FIELD : dfu_pkg::MODE_SEARCH;
                    queue_word(8'h00, 1'b0, 1'b1);
                end
            end
            dfu_pkg::MODE_ESC1:
            begin
                if (c == dfu_pkg::BACKSLASH)
                begin
                    if (!eot)
                        scan_mode = dfu_pkg::MODE_FIELD;
                    queue_word(c, 1'b1, eot);
                end
                else
                begin
                    digit         = hex_digit(c);
                    high_digit_ok = digit[4];
                    high_digit    = digit[3:0];
                    if (eot)
                        queue_word({4'h0, digit[3:0]}, 1'b1, 1'b1);
                    else
                        scan_mode = dfu_pkg::MODE_ESC2;
                end
            end
            dfu_pkg::MODE_ESC2:
            begin
                if (!eot)
                    scan_mode = dfu_pkg::MODE_FIELD;
                digit = hex_digit(c);
                if (!high_digit_ok)
                    queue_word(8'h00, 1'b1, eot);
                else if (digit[4])
                    queue_word({high_digit, digit[3:0]}, 1'b1, eot);
                else
                    queue_word({4'h0, high_digit}, 1'b1, eot);
            end
            default:
            begin
                if (c == opener)
                begin
                    if (eot)
                        queue_word(8'h00, 1'b0, 1'b1);
                    else
                        scan_mode = dfu_pkg::MODE_FIELD;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_word_t due;
        if (!rst_n)
        begin
            scan_mode     = dfu_pkg::MODE_SEARCH;
            high_digit    = 4'h0;
            high_digit_ok = 1'b0;
            delim_kind    = dfu_pkg::DELIM_BRACES;
            decoded_words_due.delete();
            words_due     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_words_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: word with nothing expected: data %02h user %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    due = decoded_words_due.pop_front();
                    if (m_tdata !== due.text)
                    begin
                        mismatches++;
                        $display("%0t: data expected %02h, got %02h", $time, due.text, m_tdata);
                    end
                    if (m_tuser !== due.is_byte)
                    begin
                        mismatches++;
                        $display("%0t: byte flag expected %0b, got %0b",
                                 $time, due.is_byte, m_tuser);
                    end
                    if (m_tlast !== due.closes)
                    begin
                        mismatches++;
                        $display("%0t: field end expected %0b, got %0b",
                                 $time, due.closes, m_tlast);
                    end
                end
                words_checked++;
                if (m_tlast === 1'b1)
                    fields_closed++;
            end
            if (cfg_valid && cfg_ready)
                delim_kind = cfg_data[0];
            if (s_tvalid && s_tready)
                decode_text_byte(s_tdata, s_tlast);
            words_due = decoded_words_due.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the unescaper testbench: clock, reset, text stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module testbench;

    localparam int QUIET_LIMIT = 1000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_data  = 1'b0;

    int   mismatches;
    int   words_due;
    int   words_checked;
    int   fields_closed;
    int   text_bytes   = 0;
    int   burst_left   = 0;
    int   stall_left   = 0;
    int   stall_style  = 0;
    int   quiet_cycles = 0;
    logic delim_kind   = dfu_pkg::DELIM_BRACES;

    delimited_field_unescaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dfu_field_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_due     (words_due),
        .words_checked (words_checked),
        .fields_closed (fields_closed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: switch between always ready, random, sparse and long stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 64);
        end
        stall_left--;
        case (stall_style)
            0:       m_tready = 1'b1;
            1:       m_tready = 1'($urandom_range(0, 1));
            2:       m_tready = (stall_left % 4 == 0);
            default: m_tready = (stall_left % 13 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] random_hex_char();
        logic [3:0] nib;
        nib = 4'($urandom_range(0, 15));
        if (nib < 4'd10)
            return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66) || b == dfu_pkg::BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] closer);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == closer || b == dfu_pkg::BACKSLASH);
        return b;
    endfunction

    // hold the word until accepted; valid stays high inside a burst
    task automatic send_word(input logic [7:0] b, input logic eot);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        text_bytes++;
    endtask

    task automatic send_string(input string text, input logic eot_at_end);
        for (int i = 0; i < text.len(); i++)
            send_word(text[i], eot_at_end && (i == text.len() - 1));
    endtask

    task automatic set_delimiter(input logic kind);
        s_tvalid = 1'b0;
        wait (words_due == 0);
        repeat (6) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = kind;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid  = 1'b0;
        delim_kind = kind;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    task automatic send_field();
        logic [7:0] opener;
        logic [7:0] closer;
        opener = delim_kind ? dfu_pkg::BRACKET_OPEN : dfu_pkg::BRACE_OPEN;
        closer = delim_kind ? dfu_pkg::BRACKET_CLOSE : dfu_pkg::BRACE_CLOSE;
        repeat ($urandom_range(0, 3))
            send_word(plain_byte(opener), $urandom_range(0, 15) == 0);
        send_word(opener, 1'b0);
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 9))
                4:
                begin
                    send_word(closer, 1'b0);
                    send_word(closer, 1'b0);
                end
                5:
                begin
                    send_word(dfu_pkg::BACKSLASH, 1'b0);
                    send_word(dfu_pkg::BACKSLASH, 1'b0);
                end
                6, 7:
                begin
                    send_word(dfu_pkg::BACKSLASH, 1'b0);
                    send_word(random_hex_char(), 1'b0);
                    send_word(random_hex_char(), 1'b0);
                end
                8:
                begin
                    send_word(dfu_pkg::BACKSLASH, 1'b0);
                    send_word($urandom_range(0, 2) == 0 ? closer : non_hex_byte(), 1'b0);
                    send_word(8'($urandom_range(0, 255)), 1'b0);
                end
                9:
                begin
                    send_word(dfu_pkg::BACKSLASH, 1'b0);
                    send_word(random_hex_char(), 1'b0);
                    send_word($urandom_range(0, 2) == 0 ? closer : non_hex_byte(), 1'b0);
                end
                default:
                    send_word(plain_byte(closer), 1'b0);
            endcase
        end
        // close normally, or cut the text off at some point of the field
        case ($urandom_range(0, 11))
            6:
                send_word(closer, 1'b1);
            7:
                send_word(plain_byte(closer), 1'b1);
            8:
                send_word(dfu_pkg::BACKSLASH, 1'b1);
            9:
            begin
                send_word(dfu_pkg::BACKSLASH, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            10:
            begin
                send_word(closer, 1'b0);
                send_word($urandom_range(0, 1) ? opener : 8'($urandom_range(0, 255)), 1'b1);
            end
            11:
            begin
                send_word(dfu_pkg::BACKSLASH, 1'b0);
                send_word(random_hex_char(), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
                send_word(closer, 1'b0);
        endcase
    endtask

    initial
    begin
        int   goal;
        logic kind;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_delimiter(dfu_pkg::DELIM_BRACES);
        send_string("x{", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_string("}}\\\\\\Ff\\gZ\\7q{\\}1}{\\a", 1'b1);

        set_delimiter(dfu_pkg::DELIM_BRACKETS);
        send_string("[", 1'b1);
        send_string("[\\", 1'b1);
        send_string("[][", 1'b1);
        send_string("[]", 1'b1);

        for (int phase = 0; phase < 6; phase++)
        begin
            kind = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
            set_delimiter(kind);
            goal = text_bytes + 80;
            while (text_bytes < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_field();
            end
        end

        s_tvalid = 1'b0;
        wait (words_due == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d text bytes over braces and brackets, with escapes and cut-off text;",
                 text_bytes);
        $display("checked %0d decoded words, %0d of them closing a field.",
                 words_checked, fields_closed);
        if (mismatches == 0 && words_due == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
